FILE: rtl/lfs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lfs_pkg
// Shared types, register indexes, microcode and the curve table of the
// line follow steering block.
// ---------------------------------------------------------------------------
package lfs_pkg;

    localparam int SENSOR_COUNT  = 5;
    localparam int CURVE_ENTRIES = 50;
    localparam int CURVE_SIZE    = 61;
    localparam int SAMPLE_W      = 8;
    localparam int POS_W         = 7;
    localparam int SENSOR_IDX_W  = $clog2(SENSOR_COUNT);
    localparam int CURVE_IDX_W   = $clog2(CURVE_SIZE);
    localparam int QUOT_W        = $clog2(CURVE_SIZE / 5 + 1);
    localparam int PC_W          = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CENTRE_IDX    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_TH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_TH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_BASE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_BOOST = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_far_left;
        logic [SAMPLE_W-1:0] sample_left;
        logic [SAMPLE_W-1:0] sample_centre;
        logic [SAMPLE_W-1:0] sample_right;
        logic [SAMPLE_W-1:0] sample_far_right;
    } in_t;

    typedef struct packed {
        logic [POS_W-1:0]  line_position;
        logic signed [7:0] turn_amount;
        logic [7:0]        left_speed;
        logic [7:0]        right_speed;
    } out_t;

    // datapath operations
    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_MIN    = 4'd2;
    localparam logic [3:0] OP_SELECT = 4'd3;
    localparam logic [3:0] OP_SCAN   = 4'd4;
    localparam logic [3:0] OP_POS    = 4'd5;
    localparam logic [3:0] OP_INTEG  = 4'd6;
    localparam logic [3:0] OP_MUL_P  = 4'd7;
    localparam logic [3:0] OP_MUL_I  = 4'd8;
    localparam logic [3:0] OP_MUL_D  = 4'd9;
    localparam logic [3:0] OP_SUM    = 4'd10;
    localparam logic [3:0] OP_TURN   = 4'd11;
    localparam logic [3:0] OP_OUT    = 4'd12;

    // sequencer conditions
    localparam logic [2:0] COND_NEXT        = 3'd0;
    localparam logic [2:0] COND_WAIT_IN     = 3'd1;
    localparam logic [2:0] COND_LOOP_SENSOR = 3'd2;
    localparam logic [2:0] COND_SKIP_FIT    = 3'd3;
    localparam logic [2:0] COND_LOOP_CURVE  = 3'd4;
    localparam logic [2:0] COND_WAIT_OUT    = 3'd5;
    localparam logic [2:0] COND_JUMP        = 3'd6;

    // program steps
    localparam logic [PC_W-1:0] STEP_LOAD   = 4'd0;
    localparam logic [PC_W-1:0] STEP_MIN    = 4'd1;
    localparam logic [PC_W-1:0] STEP_SELECT = 4'd2;
    localparam logic [PC_W-1:0] STEP_SCAN   = 4'd3;
    localparam logic [PC_W-1:0] STEP_POS    = 4'd4;
    localparam logic [PC_W-1:0] STEP_INTEG  = 4'd5;
    localparam logic [PC_W-1:0] STEP_MUL_P  = 4'd6;
    localparam logic [PC_W-1:0] STEP_MUL_I  = 4'd7;
    localparam logic [PC_W-1:0] STEP_MUL_D  = 4'd8;
    localparam logic [PC_W-1:0] STEP_SUM    = 4'd9;
    localparam logic [PC_W-1:0] STEP_TURN   = 4'd10;
    localparam logic [PC_W-1:0] STEP_OUT    = 4'd11;

    // fit modes chosen by the select step
    localparam logic [1:0] MODE_LOST  = 2'd0;
    localparam logic [1:0] MODE_LEFT  = 2'd1;
    localparam logic [1:0] MODE_RIGHT = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    typedef struct packed {
        logic [3:0]      op;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    function automatic ctrl_word_t microcode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            STEP_LOAD:   w = '{op: OP_LOAD,   cond: COND_WAIT_IN,     target: STEP_MIN};
            STEP_MIN:    w = '{op: OP_MIN,    cond: COND_LOOP_SENSOR, target: STEP_MIN};
            STEP_SELECT: w = '{op: OP_SELECT, cond: COND_SKIP_FIT,    target: STEP_POS};
            STEP_SCAN:   w = '{op: OP_SCAN,   cond: COND_LOOP_CURVE,  target: STEP_SCAN};
            STEP_POS:    w = '{op: OP_POS,    cond: COND_NEXT,        target: STEP_LOAD};
            STEP_INTEG:  w = '{op: OP_INTEG,  cond: COND_NEXT,        target: STEP_LOAD};
            STEP_MUL_P:  w = '{op: OP_MUL_P,  cond: COND_NEXT,        target: STEP_LOAD};
            STEP_MUL_I:  w = '{op: OP_MUL_I,  cond: COND_NEXT,        target: STEP_LOAD};
            STEP_MUL_D:  w = '{op: OP_MUL_D,  cond: COND_NEXT,        target: STEP_LOAD};
            STEP_SUM:    w = '{op: OP_SUM,    cond: COND_NEXT,        target: STEP_LOAD};
            STEP_TURN:   w = '{op: OP_TURN,   cond: COND_NEXT,        target: STEP_LOAD};
            STEP_OUT:    w = '{op: OP_OUT,    cond: COND_WAIT_OUT,    target: STEP_LOAD};
            default:     w = '{op: OP_NOP,    cond: COND_JUMP,        target: STEP_LOAD};
        endcase
        return w;
    endfunction

    localparam logic [7:0] CURVE_TAB [CURVE_SIZE] = '{
        8'd179, 8'd178, 8'd178, 8'd177, 8'd177, 8'd176, 8'd175, 8'd175, 8'd174,
        8'd173, 8'd172, 8'd171, 8'd170, 8'd169, 8'd168, 8'd167, 8'd165, 8'd163,
        8'd161, 8'd159, 8'd156, 8'd154, 8'd150, 8'd146, 8'd142, 8'd137, 8'd131,
        8'd125, 8'd118, 8'd110, 8'd102, 8'd94,  8'd86,  8'd79,  8'd73,  8'd67,
        8'd62,  8'd58,  8'd54,  8'd50,  8'd48,  8'd45,  8'd43,  8'd41,  8'd39,
        8'd37,  8'd36,  8'd35,  8'd34,  8'd33,  8'd32,  8'd31,  8'd30,  8'd29,
        8'd29,  8'd28,  8'd27,  8'd27,  8'd26,  8'd26,  8'd25
    };

endpackage
`default_nettype wire

FILE: rtl/line_follow_steering_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// line_follow_steering_top
// Line position estimate from five reflectance samples, PID steering and
// two clamped motor speeds, run by a small microcoded sequencer.
// ---------------------------------------------------------------------------
// One item at a time: a frame with the line seen and a usable neighbour runs
// 1 load, 4 darkest-sensor compares, 1 select, 50 curve-fit steps and 8
// position/PID/speed steps from its transfer to its result; a frame without
// a fit skips the curve-fit steps. The 50-entry curve scan takes one table
// entry per cycle; the PID terms share one 9x16 multiplier.
// A new frame is taken as soon as the previous result sits in the output
// register, even if it is still stalled. Configuration is always ready.
module line_follow_steering_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire lfs_pkg::in_t in_data,
    output logic              out_valid,
    input  wire logic         out_stall,
    output lfs_pkg::out_t     out_data,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [7:0]   cfg_data
);
    import lfs_pkg::*;

    localparam logic [SENSOR_IDX_W-1:0] SENSOR_LAST = SENSOR_IDX_W'(SENSOR_COUNT - 1);
    localparam logic [CURVE_IDX_W-1:0]  CURVE_LAST  = CURVE_IDX_W'(CURVE_ENTRIES - 1);

    // configuration
    logic [7:0] line_th_reg, side_th_reg, gain_prop_reg, gain_integ_reg;
    logic [7:0] gain_deriv_reg, speed_base_reg, speed_limit_reg, speed_boost_reg;

    // sequencer
    logic [PC_W-1:0] pc_reg, pc_next;
    ctrl_word_t      cw;

    // persistent state
    logic [POS_W-1:0]   held_pos_reg, held_pos_next;
    logic signed [15:0] esum_reg, esum_next;
    logic signed [7:0]  prev_err_reg;

    // datapath
    logic [SAMPLE_W-1:0]     s_reg [SENSOR_COUNT];
    logic [SENSOR_IDX_W-1:0] sidx_reg, m_reg;
    logic [SAMPLE_W-1:0]     min_val_reg, prev_val_reg, left_val_reg, right_val_reg;
    logic                    want_right_reg;
    logic [1:0]              mode_reg, mode_next;
    logic [SAMPLE_W-1:0]     fit_a_reg, fit_b_reg, fit_a_next, fit_b_next;
    logic [CURVE_IDX_W-1:0]  scan_idx_reg;
    logic [QUOT_W-1:0]       idx_q_reg, best_q_reg;
    logic [2:0]              idx_r_reg;
    logic [9:0]              best_cost_reg;
    logic signed [7:0]       err_reg, err_next;
    logic signed [8:0]       deriv_reg, deriv_next;
    logic signed [24:0]      prod_reg, mul_w;
    logic signed [25:0]      acc_reg;
    logic signed [7:0]       turn_reg, turn_next;

    logic                out_valid_reg;
    out_t                out_data_reg, out_data_next;
    logic                in_accept, can_load;
    logic [SAMPLE_W-1:0] cur_sample;

    assign cw        = microcode(pc_reg);
    assign in_stall  = (pc_reg != STEP_LOAD);
    assign in_accept = in_valid && !in_stall;
    assign can_load  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;
    assign cur_sample = s_reg[sidx_reg];

    // neighbour choice for the fit
    always_comb
    begin
        mode_next  = MODE_NONE;
        fit_a_next = min_val_reg;
        fit_b_next = right_val_reg;
        if (!(min_val_reg < line_th_reg))
        begin
            mode_next = MODE_LOST;
        end
        else if (m_reg != '0 && left_val_reg < side_th_reg)
        begin
            mode_next  = MODE_LEFT;
            fit_a_next = left_val_reg;
            fit_b_next = min_val_reg;
        end
        else if (m_reg != SENSOR_LAST && right_val_reg < side_th_reg)
        begin
            mode_next = MODE_RIGHT;
        end
    end

    // curve fit cost for the current table entry
    logic [7:0] curve_c, curve_t, diff_a, diff_b;
    logic [9:0] cost;
    always_comb
    begin
        curve_c = CURVE_TAB[scan_idx_reg];
        curve_t = 8'd204 - curve_c;
        diff_a  = (fit_a_reg > curve_c) ? fit_a_reg - curve_c : curve_c - fit_a_reg;
        diff_b  = (fit_b_reg > curve_t) ? fit_b_reg - curve_t : curve_t - fit_b_reg;
        cost    = {2'b0, diff_a} + {2'b0, diff_b};
    end

    // position and error
    logic [7:0] m20, fit8, pos8;
    always_comb
    begin
        m20  = ({5'b0, m_reg} << 4) + ({5'b0, m_reg} << 2);
        fit8 = {{(8 - QUOT_W){1'b0}}, best_q_reg} + 8'd10;
        pos8 = {1'b0, held_pos_reg};
        case (mode_reg)
            MODE_LEFT:  pos8 = m20 - 8'd10 + fit8;
            MODE_RIGHT: pos8 = m20 + 8'd10 + fit8;
            MODE_NONE:  pos8 = m20 + 8'd10;
            default:
            begin
                if (held_pos_reg == 7'd10)
                    pos8 = 8'd0;
                else if (held_pos_reg == 7'd90)
                    pos8 = 8'd100;
            end
        endcase
        held_pos_next = pos8[POS_W-1:0];
        err_next      = 8'sd50 - $signed({1'b0, held_pos_next});
    end

    // integral with saturation, derivative
    logic [7:0]         err_mag;
    logic [1:0]         q_mag;
    logic signed [2:0]  q_val;
    logic signed [16:0] esum_wide;
    always_comb
    begin
        err_mag = err_reg[7] ? 8'(-err_reg) : err_reg;
        if (err_mag >= 8'd40)
            q_mag = 2'd2;
        else if (err_mag >= 8'd20)
            q_mag = 2'd1;
        else
            q_mag = 2'd0;
        q_val = err_reg[7] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        esum_wide = {esum_reg[15], esum_reg} + {{14{q_val[2]}}, q_val};
        if (err_reg == 8'sd0)
            esum_next = '0;
        else if (esum_wide[16] != esum_wide[15])
            esum_next = esum_wide[16] ? 16'sh8000 : 16'sh7FFF;
        else
            esum_next = esum_wide[15:0];
        deriv_next = {err_reg[7], err_reg} - {prev_err_reg[7], prev_err_reg};
    end

    // shared multiplier
    logic signed [8:0]  mul_a;
    logic signed [15:0] mul_b;
    always_comb
    begin
        case (cw.op)
            OP_MUL_I:
            begin
                mul_a = $signed({1'b0, gain_integ_reg});
                mul_b = esum_reg;
            end
            OP_MUL_D:
            begin
                mul_a = $signed({1'b0, gain_deriv_reg});
                mul_b = {{7{deriv_reg[8]}}, deriv_reg};
            end
            default:
            begin
                mul_a = $signed({1'b0, gain_prop_reg});
                mul_b = {{8{err_reg[7]}}, err_reg};
            end
        endcase
        mul_w = mul_a * mul_b;
    end

    always_comb
    begin
        if (acc_reg > 26'sd127)
            turn_next = 8'sd127;
        else if (acc_reg < -26'sd127)
            turn_next = -8'sd127;
        else
            turn_next = acc_reg[7:0];
    end

    // motor speeds
    logic               boost;
    logic [8:0]         base9, lim9;
    logic [7:0]         lim8;
    logic signed [10:0] left11, right11, lim11;
    always_comb
    begin
        boost   = s_reg[CENTRE_IDX] < line_th_reg;
        base9   = {1'b0, speed_base_reg} + (boost ? {1'b0, speed_boost_reg} : 9'd0);
        lim9    = {1'b0, speed_limit_reg} + (boost ? {1'b0, speed_boost_reg} : 9'd0);
        lim8    = lim9[8] ? 8'hFF : lim9[7:0];
        lim11   = $signed({3'b0, lim8});
        left11  = $signed({2'b0, base9}) - {{3{turn_reg[7]}}, turn_reg};
        right11 = $signed({2'b0, base9}) + {{3{turn_reg[7]}}, turn_reg};
        out_data_next.line_position = held_pos_reg;
        out_data_next.turn_amount   = turn_reg;
        if (left11 < 11'sd0)
            out_data_next.left_speed = 8'd0;
        else if (left11 > lim11)
            out_data_next.left_speed = lim8;
        else
            out_data_next.left_speed = left11[7:0];
        if (right11 < 11'sd0)
            out_data_next.right_speed = 8'd0;
        else if (right11 > lim11)
            out_data_next.right_speed = lim8;
        else
            out_data_next.right_speed = right11[7:0];
    end

    // step counter
    always_comb
    begin
        case (cw.cond)
            COND_NEXT:        pc_next = pc_reg + 1'b1;
            COND_WAIT_IN:     pc_next = in_valid ? pc_reg + 1'b1 : pc_reg;
            COND_LOOP_SENSOR: pc_next = (sidx_reg != SENSOR_LAST) ? cw.target : pc_reg + 1'b1;
            COND_SKIP_FIT:    pc_next = (mode_next == MODE_LOST || mode_next == MODE_NONE)
                                        ? cw.target : pc_reg + 1'b1;
            COND_LOOP_CURVE:  pc_next = (scan_idx_reg != CURVE_LAST) ? cw.target
                                        : pc_reg + 1'b1;
            COND_WAIT_OUT:    pc_next = can_load ? cw.target : pc_reg;
            default:          pc_next = cw.target;
        endcase
    end

    // control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg          <= STEP_LOAD;
            out_valid_reg   <= 1'b0;
            held_pos_reg    <= '0;
            esum_reg        <= '0;
            prev_err_reg    <= '0;
            line_th_reg     <= 8'd100;
            side_th_reg     <= 8'd150;
            gain_prop_reg   <= 8'd2;
            gain_integ_reg  <= 8'd0;
            gain_deriv_reg  <= 8'd1;
            speed_base_reg  <= 8'd120;
            speed_limit_reg <= 8'd200;
            speed_boost_reg <= 8'd0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (cw.op == OP_OUT && can_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cw.op == OP_POS)
                held_pos_reg <= held_pos_next;
            if (cw.op == OP_INTEG)
            begin
                esum_reg     <= esum_next;
                prev_err_reg <= err_reg;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_LINE_TH:     line_th_reg     <= cfg_data;
                    CFG_SIDE_TH:     side_th_reg     <= cfg_data;
                    CFG_GAIN_PROP:   gain_prop_reg   <= cfg_data;
                    CFG_GAIN_INTEG:  gain_integ_reg  <= cfg_data;
                    CFG_GAIN_DERIV:  gain_deriv_reg  <= cfg_data;
                    CFG_SPEED_BASE:  speed_base_reg  <= cfg_data;
                    CFG_SPEED_LIMIT: speed_limit_reg <= cfg_data;
                    CFG_SPEED_BOOST: speed_boost_reg <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (cw.op)
            OP_LOAD:
            begin
                if (in_accept)
                begin
                    s_reg[0]       <= in_data.sample_far_left;
                    s_reg[1]       <= in_data.sample_left;
                    s_reg[2]       <= in_data.sample_centre;
                    s_reg[3]       <= in_data.sample_right;
                    s_reg[4]       <= in_data.sample_far_right;
                    min_val_reg    <= in_data.sample_far_left;
                    prev_val_reg   <= in_data.sample_far_left;
                    m_reg          <= '0;
                    sidx_reg       <= SENSOR_IDX_W'(1);
                    want_right_reg <= 1'b1;
                end
            end
            OP_MIN:
            begin
                // right neighbour of the darkest so far is taken from the next sample compared
                if (want_right_reg)
                    right_val_reg <= cur_sample;
                if (cur_sample < min_val_reg)
                begin
                    m_reg          <= sidx_reg;
                    min_val_reg    <= cur_sample;
                    left_val_reg   <= prev_val_reg;
                    want_right_reg <= 1'b1;
                end
                else
                begin
                    want_right_reg <= 1'b0;
                end
                prev_val_reg <= cur_sample;
                sidx_reg     <= sidx_reg + 1'b1;
            end
            OP_SELECT:
            begin
                mode_reg      <= mode_next;
                fit_a_reg     <= fit_a_next;
                fit_b_reg     <= fit_b_next;
                scan_idx_reg  <= '0;
                idx_q_reg     <= '0;
                idx_r_reg     <= '0;
                best_cost_reg <= '1;
                best_q_reg    <= '0;
            end
            OP_SCAN:
            begin
                // first entry with the least cost wins
                if (cost < best_cost_reg)
                begin
                    best_cost_reg <= cost;
                    best_q_reg    <= idx_q_reg;
                end
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (idx_r_reg == 3'd4)
                begin
                    idx_r_reg <= '0;
                    idx_q_reg <= idx_q_reg + 1'b1;
                end
                else
                begin
                    idx_r_reg <= idx_r_reg + 1'b1;
                end
            end
            OP_POS:
            begin
                err_reg <= err_next;
            end
            OP_INTEG:
            begin
                deriv_reg <= deriv_next;
            end
            OP_MUL_P:
            begin
                prod_reg <= mul_w;
            end
            OP_MUL_I:
            begin
                acc_reg  <= {prod_reg[24], prod_reg};
                prod_reg <= mul_w;
            end
            OP_MUL_D:
            begin
                acc_reg  <= acc_reg + {prod_reg[24], prod_reg};
                prod_reg <= mul_w;
            end
            OP_SUM:
            begin
                acc_reg <= acc_reg + {prod_reg[24], prod_reg};
            end
            OP_TURN:
            begin
                turn_reg <= turn_next;
            end
            OP_OUT:
            begin
                if (can_load)
                    out_data_reg <= out_data_next;
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts_min: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> pc_reg == STEP_MIN)
        else $error("transfer did not start the darkest-sensor search");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_SCAN) |-> (scan_idx_reg < CURVE_IDX_W'(CURVE_ENTRIES)))
        else $error("curve scan ran past the table");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.line_position <= 7'd100))
        else $error("line position out of range");

    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.turn_amount != -8'sd128))
        else $error("turn amount not saturated");
`endif

endmodule
`default_nettype wire

FILE: test/lfs_steer_checker.sv
// ---------------------------------------------------------------------------
// lfs_steer_checker
// Watches the frame, result and register channels of the line follow
// steering block. It keeps its own copy of the registers and of the
// position/PID state, works out the result of every frame transfer and
// compares each result transfer with the oldest one still awaited.
// ---------------------------------------------------------------------------
module lfs_steer_checker
    import lfs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire in_t        in_data,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire out_t       out_data,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output int              fail_count,
    output int              pending,
    output int              checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copy
    int line_th;
    int side_th;
    int k_prop;
    int k_integ;
    int k_deriv;
    int spd_base;
    int spd_limit;
    int spd_boost;

    // steering state
    logic [POS_W-1:0] held_pos;
    int               integ_acc;
    int               last_err;

    out_t awaited_steer [$];
    out_t want;

    // offset 10..19 from the best match of a neighbour pair against the curve
    function automatic int curve_offset(input int a, input int b);
        int best_cost;
        int best_idx;
        int c;
        int cost;
        best_cost = 32'h7fff_ffff;
        best_idx  = 0;
        for (int i = 0; i < CURVE_ENTRIES && i < CURVE_SIZE; i++)
        begin
            c    = CURVE_TAB[i];
            cost = ((a > c) ? a - c : c - a)
                 + ((b > 204 - c) ? b - (204 - c) : (204 - c) - b);
            if (cost < best_cost)
            begin
                best_cost = cost;
                best_idx  = i;
            end
        end
        return best_idx / 5 + 10;
    endfunction

    function automatic out_t steer_frame(input in_t f);
        int   s [SENSOR_COUNT];
        int   dark;
        int   err;
        int   deriv;
        int   pid_sum;
        int   turn;
        int   base;
        int   lim;
        int   lft;
        int   rgt;
        out_t r;
        s[0] = f.sample_far_left;
        s[1] = f.sample_left;
        s[2] = f.sample_centre;
        s[3] = f.sample_right;
        s[4] = f.sample_far_right;

        dark = 0;
        for (int i = 1; i < SENSOR_COUNT; i++)
            if (s[i] < s[dark])
                dark = i;

        if (s[dark] < line_th)
        begin
            if (dark != 0 && s[dark-1] < side_th)
                held_pos = POS_W'(20 * dark - 10 + curve_offset(s[dark-1], s[dark]));
            else if (dark != SENSOR_COUNT - 1 && s[dark+1] < side_th)
                held_pos = POS_W'(20 * dark + 10 + curve_offset(s[dark], s[dark+1]));
            else
                held_pos = POS_W'(20 * dark + 10);
        end
        // line lost: an edge position is pushed fully out
        else if (held_pos == 10)
            held_pos = 0;
        else if (held_pos == 90)
            held_pos = 100;

        err       = 50 - int'(held_pos);
        integ_acc = integ_acc + err / 20;
        if (integ_acc > 32767)
            integ_acc = 32767;
        else if (integ_acc < -32768)
            integ_acc = -32768;
        deriv = err - last_err;
        if (err == 0)
            integ_acc = 0;
        pid_sum  = k_prop * err + k_integ * integ_acc + k_deriv * deriv;
        last_err = err;
        turn = (pid_sum > 127) ? 127 : (pid_sum < -127) ? -127 : pid_sum;

        base = spd_base;
        lim  = spd_limit;
        if (s[CENTRE_IDX] < line_th)
        begin
            base += spd_boost;
            lim  += spd_boost;
        end
        if (lim > 255)
            lim = 255;
        lft = base - turn;
        rgt = base + turn;
        lft = (lft < 0) ? 0 : (lft > lim) ? lim : lft;
        rgt = (rgt < 0) ? 0 : (rgt > lim) ? lim : rgt;

        r.line_position = held_pos;
        r.turn_amount   = turn[7:0];
        r.left_speed    = lft[7:0];
        r.right_speed   = rgt[7:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_th    = 100;
            side_th    = 150;
            k_prop     = 2;
            k_integ    = 0;
            k_deriv    = 1;
            spd_base   = 120;
            spd_limit  = 200;
            spd_boost  = 0;
            held_pos   = '0;
            integ_acc  = 0;
            last_err   = 0;
            fail_count = 0;
            checked    = 0;
            awaited_steer.delete();
        end
        else
        begin
            // compare before queueing, a result never belongs to a frame of the same edge
            if (out_valid && !out_stall)
            begin
                checked++;
                if (awaited_steer.size() == 0)
                begin
                    $error("result transfer with nothing awaited: %p", out_data);
                    fail_count++;
                end
                else
                begin
                    want = awaited_steer.pop_front();
                    if (out_data.line_position !== want.line_position)
                    begin
                        $error("line_position: expected %0d, got %0d",
                               want.line_position, out_data.line_position);
                        fail_count++;
                    end
                    if (out_data.turn_amount !== want.turn_amount)
                    begin
                        $error("turn_amount: expected %0d, got %0d",
                               want.turn_amount, out_data.turn_amount);
                        fail_count++;
                    end
                    if (out_data.left_speed !== want.left_speed)
                    begin
                        $error("left_speed: expected %0d, got %0d",
                               want.left_speed, out_data.left_speed);
                        fail_count++;
                    end
                    if (out_data.right_speed !== want.right_speed)
                    begin
                        $error("right_speed: expected %0d, got %0d",
                               want.right_speed, out_data.right_speed);
                        fail_count++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LINE_TH:     line_th   = cfg_data;
                    CFG_SIDE_TH:     side_th   = cfg_data;
                    CFG_GAIN_PROP:   k_prop    = cfg_data;
                    CFG_GAIN_INTEG:  k_integ   = cfg_data;
                    CFG_GAIN_DERIV:  k_deriv   = cfg_data;
                    CFG_SPEED_BASE:  spd_base  = cfg_data;
                    CFG_SPEED_LIMIT: spd_limit = cfg_data;
                    CFG_SPEED_BOOST: spd_boost = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                awaited_steer.push_back(steer_frame(in_data));
        end
        pending = awaited_steer.size();
    end

endmodule

FILE: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Drives the line follow steering block with directed sensor frames, then
// with random line-shaped and noise frames over several register settings,
// including all-ones and all-zeros, with random gaps on both channels and
// one long output hold. Checking is done by lfs_steer_checker.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lfs_pkg::*;

    localparam int PHASES          = 8;
    localparam int FRAMES_PER_SET  = 120;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 80;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_t        in_data;
    logic       out_valid;
    logic       out_stall;
    out_t       out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    int fail_count;
    int pending;
    int checked;
    int frames_sent;
    int settings_used;
    bit no_gaps;
    bit hold_req;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    line_follow_steering_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lfs_steer_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    function automatic in_t frame(input int a, input int b, input int c,
                                  input int d, input int e);
        in_t f;
        f.sample_far_left  = a[7:0];
        f.sample_left      = b[7:0];
        f.sample_centre    = c[7:0];
        f.sample_right     = d[7:0];
        f.sample_far_right = e[7:0];
        return f;
    endfunction

    function automatic in_t random_frame();
        int s [SENSOR_COUNT];
        int kind;
        int m;
        int v;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            // dark line under one sensor, neighbours sometimes half covered
            m = $urandom_range(0, SENSOR_COUNT - 1);
            for (int i = 0; i < SENSOR_COUNT; i++)
                s[i] = $urandom_range(150, 255);
            s[m] = $urandom_range(0, 110);
            if (m > 0 && $urandom_range(0, 1))
                s[m-1] = $urandom_range(s[m], 190);
            if (m < SENSOR_COUNT - 1 && $urandom_range(0, 1))
                s[m+1] = $urandom_range(s[m], 190);
        end
        else if (kind <= 7)
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
                s[i] = $urandom_range(0, 255);
        end
        else if (kind == 8)
        begin
            // bright floor, mostly no line
            for (int i = 0; i < SENSOR_COUNT; i++)
                s[i] = $urandom_range(100, 255);
        end
        else
        begin
            // equal darkest samples
            v = $urandom_range(0, 160);
            for (int i = 0; i < SENSOR_COUNT; i++)
                s[i] = $urandom_range(v, 255);
            s[$urandom_range(0, SENSOR_COUNT - 1)] = v;
            s[$urandom_range(0, SENSOR_COUNT - 1)] = v;
        end
        return frame(s[0], s[1], s[2], s[3], s[4]);
    endfunction

    // all ones, all zeros, near-typical or fully random depending on the set
    function automatic logic [7:0] reg_value(input int ph, input int typical);
        int v;
        if (ph == 0)
            return 8'hff;
        if (ph == 1)
            return 8'h00;
        if (ph % 2 == 0)
        begin
            v = typical + $urandom_range(0, 40) - 20;
            v = (v < 0) ? 0 : (v > 255) ? 255 : v;
            return v[7:0];
        end
        v = $urandom_range(0, 255);
        return v[7:0];
    endfunction

    task automatic send_frame(input in_t f);
        if (!no_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_data  = f;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        frames_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic program_regs(input int ph);
        write_reg(CFG_LINE_TH,     reg_value(ph, 100));
        write_reg(CFG_SIDE_TH,     reg_value(ph, 150));
        write_reg(CFG_GAIN_PROP,   reg_value(ph, 3));
        write_reg(CFG_GAIN_INTEG,  reg_value(ph, 1));
        write_reg(CFG_GAIN_DERIV,  reg_value(ph, 4));
        write_reg(CFG_SPEED_BASE,  reg_value(ph, 120));
        write_reg(CFG_SPEED_LIMIT, reg_value(ph, 200));
        write_reg(CFG_SPEED_BOOST, reg_value(ph, 30));
        cfg_valid = 1'b0;
        settings_used++;
    endtask

    // result side: random stall bursts, plus one long hold on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req  = 1'b0;
                out_stall = 1'b0;
            end
            else if (!no_gaps && $urandom_range(0, 7) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // watchdog: too long without any transfer ends the run
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_LINE_TH;
        cfg_data      = '0;
        no_gaps       = 1'b0;
        hold_req      = 1'b0;
        frames_sent   = 0;
        settings_used = 1;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset register values: edges, line lost, thresholds, neighbours
        send_frame(frame(255, 255, 255, 255, 255));
        send_frame(frame(0, 255, 255, 255, 255));
        send_frame(frame(255, 255, 255, 255, 255));
        send_frame(frame(255, 255, 255, 255, 0));
        send_frame(frame(255, 255, 255, 255, 255));
        send_frame(frame(255, 255, 255, 255, 255));
        send_frame(frame(255, 120, 40, 255, 255));
        send_frame(frame(255, 255, 40, 120, 255));
        send_frame(frame(0, 0, 0, 0, 0));
        send_frame(frame(99, 255, 255, 255, 255));
        send_frame(frame(100, 255, 255, 255, 255));
        send_frame(frame(255, 255, 255, 149, 0));
        send_frame(frame(255, 255, 255, 150, 0));
        send_frame(frame(255, 40, 255, 40, 255));
        wait_drained();

        // centre boost past the speed ceiling, turn saturation both ways
        write_reg(CFG_SPEED_BOOST, 8'd40);
        write_reg(CFG_GAIN_INTEG,  8'd3);
        write_reg(CFG_SPEED_LIMIT, 8'd255);
        write_reg(CFG_SPEED_BASE,  8'd250);
        cfg_valid = 1'b0;
        settings_used++;
        send_frame(frame(255, 255, 10, 255, 255));
        send_frame(frame(10, 255, 255, 255, 255));
        send_frame(frame(255, 255, 255, 255, 10));
        send_frame(frame(255, 255, 10, 200, 255));
        send_frame(frame(255, 255, 255, 255, 255));
        send_frame(frame(0, 255, 255, 255, 255));
        send_frame(frame(255, 255, 0, 0, 255));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            program_regs(ph);
            if (ph == PHASES - 1)
                no_gaps = 1'b1;
            if (ph == 3)
                hold_req = 1'b1;
            repeat (FRAMES_PER_SET) send_frame(random_frame());
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d frames and %0d checked results over %0d register settings",
                 frames_sent, checked, settings_used);
        $display("including all-ones and all-zeros registers and a %0d-cycle output hold",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: line_follow_steering_top.f
rtl/lfs_pkg.sv
rtl/line_follow_steering_top.sv
test/lfs_steer_checker.sv
test/tb_top.sv
